[rtl/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

[rtl/gbd_pkg.sv]
// Shared constants, register indexes and controller/datapath interface types.
package gbd_pkg;

  localparam int unsigned MaxBinsDefault = 512;

  // Configuration port
  localparam int unsigned CfgW    = 13;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SCALE_FACTOR = 2'd2;

  localparam logic [CfgW-1:0] WidthReset  = 13'd320;
  localparam logic [CfgW-1:0] HeightReset = 13'd240;
  localparam logic [4:0]      ScaleReset  = 5'd2;
  localparam logic [CfgW-1:0] DimMax      = 13'd4096;
  localparam logic [4:0]      ScaleMax    = 5'd16;

  // Luma weights, sum to 65536
  localparam logic [15:0] LumaCoefR = 16'd19595;
  localparam logic [15:0] LumaCoefG = 16'd38470;
  localparam logic [15:0] LumaCoefB = 16'd7471;

  localparam int unsigned PixW  = 8;
  localparam int unsigned PosW  = 12;
  localparam int unsigned SubW  = 4;
  localparam int unsigned RigW  = 5;
  localparam int unsigned SumW  = 16;
  localparam int unsigned DivW  = 9;
  localparam int unsigned ColW  = 9;
  localparam int unsigned StepW = 4;
  localparam int unsigned DivSteps = SumW;

  typedef struct packed {
    logic accept;
    logic prod_en;
    logic sum_en;
    logic div_step;
    logic out_load;
  } gbd_cmd_t;

  typedef struct packed {
    logic emit;
    logic out_busy;
  } gbd_status_t;

endpackage

[rtl/gbd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gbd_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 512,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/gbd_datapath.sv]
// Datapath: config registers, raster counters, luma, bin sums, divider, result register.
module gbd_datapath #(
  parameter int unsigned MAX_BINS = gbd_pkg::MaxBinsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gbd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gbd_pkg::CfgW-1:0]     cfg_data_i,
  input  logic [gbd_pkg::PixW-1:0]     pixel_red_i,
  input  logic [gbd_pkg::PixW-1:0]     pixel_green_i,
  input  logic [gbd_pkg::PixW-1:0]     pixel_blue_i,
  input  gbd_pkg::gbd_cmd_t            cmd_i,
  output gbd_pkg::gbd_status_t         status_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [gbd_pkg::PixW-1:0]     gray_average_o,
  output logic [gbd_pkg::ColW-1:0]     bin_column_o,
  output logic [gbd_pkg::PosW-1:0]     bin_row_o,
  output logic                         frame_end_o
);
  import gbd_pkg::*;

  localparam int unsigned AddrW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam logic [PosW:0]   BinLimit = (PosW+1)'(MAX_BINS);
  localparam logic [PosW-1:0] BinLast  = PosW'(MAX_BINS - 1);

  // Configuration
  logic [CfgW-1:0] width_q, height_q;
  logic [4:0]      scale_q;
  logic [CfgW-1:0] w_eff, h_eff;
  logic [4:0]      s_eff;
  logic            cfg_hit;

  // Raster position
  logic [PosW-1:0] col_q, row_q, grp_q, bin_q;
  logic [SubW-1:0] sub_q;
  logic [RigW-1:0] rig_q;

  logic last_col, last_row, group_last, sub_last, in_range;
  logic [RigW-1:0] rows_n;
  logic [4:0]      bw_n;
  logic [9:0]      div_full;

  // Per-request context
  logic [PixW-1:0] red_q, green_q, blue_q;
  logic            load_q, emit_q, wr_q, fe_q;
  logic [PosW-1:0] ctx_bin_q, ctx_grp_q;
  logic [DivW-1:0] div_q;

  // Luma and accumulation
  logic [23:0]     prod_r_q, prod_g_q, prod_b_q;
  logic [24:0]     luma_sum;
  logic [SumW-1:0] acc, rdata;

  // Divider
  logic [SumW-1:0] num_q;
  logic [DivW-1:0] rem_q;
  logic [DivW:0]   trial;
  logic            ge;

  // Result register
  logic            out_valid_q, fe_out_q;
  logic [PixW-1:0] gray_q;
  logic [ColW-1:0] col_out_q;
  logic [PosW-1:0] row_out_q;

  always_comb begin
    w_eff = (width_q == '0) ? CfgW'(1) : ((width_q > DimMax) ? DimMax : width_q);
    h_eff = (height_q == '0) ? CfgW'(1) : ((height_q > DimMax) ? DimMax : height_q);
    s_eff = (scale_q == '0) ? 5'd1 : ((scale_q > ScaleMax) ? ScaleMax : scale_q);
  end

  assign cfg_hit    = cfg_we_i && (cfg_index_i == CFG_IMAGE_WIDTH ||
                                   cfg_index_i == CFG_IMAGE_HEIGHT ||
                                   cfg_index_i == CFG_SCALE_FACTOR);
  assign last_col   = ({1'b0, col_q} + 13'd1) >= w_eff;
  assign last_row   = ({1'b0, row_q} + 13'd1) >= h_eff;
  assign group_last = (({1'b0, rig_q} + 6'd1) >= {1'b0, s_eff}) || last_row;
  assign sub_last   = ({1'b0, sub_q} + 5'd1) == s_eff;
  assign in_range   = {1'b0, bin_q} < BinLimit;
  assign rows_n     = rig_q + RigW'(1);
  assign bw_n       = {1'b0, sub_q} + 5'd1;
  assign div_full   = {5'b0, rows_n} * {5'b0, bw_n};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      scale_q  <= ScaleReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        CFG_SCALE_FACTOR: scale_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Raster counters restart on a configuration write and advance when a pixel request is accepted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      grp_q <= '0;
      bin_q <= '0;
      sub_q <= '0;
      rig_q <= '0;
    end else if (cfg_hit) begin
      col_q <= '0;
      row_q <= '0;
      grp_q <= '0;
      bin_q <= '0;
      sub_q <= '0;
      rig_q <= '0;
    end else if (cmd_i.accept) begin
      if (last_col) begin
        col_q <= '0;
        bin_q <= '0;
        sub_q <= '0;
        if (last_row) begin
          row_q <= '0;
          grp_q <= '0;
          rig_q <= '0;
        end else begin
          row_q <= row_q + PosW'(1);
          if (group_last) begin
            rig_q <= '0;
            grp_q <= grp_q + PosW'(1);
          end else begin
            rig_q <= rig_q + RigW'(1);
          end
        end
      end else begin
        col_q <= col_q + PosW'(1);
        if (sub_last) begin
          sub_q <= '0;
          bin_q <= bin_q + PosW'(1);
        end else begin
          sub_q <= sub_q + SubW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q <= 1'b0;
      wr_q   <= 1'b0;
    end else if (cmd_i.accept) begin
      emit_q <= in_range && group_last && (sub_last || last_col);
      wr_q   <= in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      red_q     <= pixel_red_i;
      green_q   <= pixel_green_i;
      blue_q    <= pixel_blue_i;
      load_q    <= (rig_q == '0) && (sub_q == '0);
      fe_q      <= last_row && (last_col || bin_q == BinLast);
      ctx_bin_q <= bin_q;
      ctx_grp_q <= grp_q;
      div_q     <= div_full[DivW-1:0];
    end
    if (cmd_i.prod_en) begin
      prod_r_q <= red_q * LumaCoefR;
      prod_g_q <= green_q * LumaCoefG;
      prod_b_q <= blue_q * LumaCoefB;
    end
  end

  assign luma_sum = {1'b0, prod_r_q} + {1'b0, prod_g_q} + {1'b0, prod_b_q};
  assign acc      = load_q ? {8'b0, luma_sum[23:16]} : rdata + {8'b0, luma_sum[23:16]};

  gbd_ram #(
    .Width(SumW),
    .Depth(MAX_BINS),
    .AddrW(AddrW)
  ) u_bin_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.sum_en && wr_q),
    .waddr_i(ctx_bin_q[AddrW-1:0]),
    .wdata_i(acc),
    .re_i   (cmd_i.accept),
    .raddr_i(bin_q[AddrW-1:0]),
    .rdata_o(rdata)
  );

  // Restoring divider, one quotient bit per step
  assign trial = {rem_q, num_q[SumW-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en) begin
      num_q <= acc;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[SumW-2:0], ge};
      rem_q <= ge ? DivW'(trial - {1'b0, div_q}) : trial[DivW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      gray_q    <= num_q[PixW-1:0];
      col_out_q <= ctx_bin_q[ColW-1:0];
      row_out_q <= ctx_grp_q;
      fe_out_q  <= fe_q;
    end
  end

  assign status_o.emit     = emit_q;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign gray_average_o = gray_q;
  assign bin_column_o   = col_out_q;
  assign bin_row_o      = row_out_q;
  assign frame_end_o    = fe_out_q;

endmodule

[rtl/gbd_ctrl.sv]
// Controller: luma and accumulate per request; divide and output when it closes a block.
module gbd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  gbd_pkg::gbd_status_t status_i,
  output gbd_pkg::gbd_cmd_t    cmd_o
);
  import gbd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_SUM,
    S_DIV,
    S_OUT
  } state_e;

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             in_ready_q;
  logic             accept;

  assign accept = in_valid_i && in_ready_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.accept = accept;
        if (accept) state_d = S_PROD;
      end
      S_PROD: begin
        cmd_o.prod_en = 1'b1;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum_en = 1'b1;
        step_d = '0;
        state_d = status_i.emit ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(DivSteps - 1)) state_d = S_OUT;
      end
      S_OUT: begin
        // wait until the result register can take the new result
        cmd_o.out_load = !status_i.out_busy;
        if (!status_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      step_q     <= '0;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      in_ready_q <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = in_ready_q;

endmodule

[rtl/grayscale_block_downsample.sv]
// A pixel that closes a block passes product, bin-sum, divider and result registers.
// A new pixel is taken only once the last is done; one that closes a block also runs
// the 16-step divider and waits while a stalled output still holds the result register.
// Reset: asynchronous active low; registers return to 320x240, scale 2, frame restarts.
// Bin sums are not cleared; the first pixel of each bin in the first row of a group loads them.
module grayscale_block_downsample #(
  parameter int unsigned MAX_BINS = gbd_pkg::MaxBinsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gbd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [gbd_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [gbd_pkg::PixW-1:0]    pixel_red_i,
  input  logic [gbd_pkg::PixW-1:0]    pixel_green_i,
  input  logic [gbd_pkg::PixW-1:0]    pixel_blue_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gbd_pkg::PixW-1:0]    gray_average_o,
  output logic [gbd_pkg::ColW-1:0]    bin_column_o,
  output logic [gbd_pkg::PosW-1:0]    bin_row_o,
  output logic                        frame_end_o
);
  import gbd_pkg::*;

  gbd_cmd_t    cmd;
  gbd_status_t status;

  gbd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  gbd_datapath #(
    .MAX_BINS(MAX_BINS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_red_i   (pixel_red_i),
    .pixel_green_i (pixel_green_i),
    .pixel_blue_i  (pixel_blue_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .gray_average_o(gray_average_o),
    .bin_column_o  (bin_column_o),
    .bin_row_o     (bin_row_o),
    .frame_end_o   (frame_end_o)
  );

endmodule

[rtl/gbd_checker.sv]
// Port-level checker for the downsampler, bound to the top level.
`include "assert_macros.svh"

module gbd_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [gbd_pkg::PixW-1:0] gray_average_o,
  input logic [gbd_pkg::ColW-1:0] bin_column_o
);

  // stalled result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(gray_average_o) && $stable(bin_column_o))
  // one request in flight at a time
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // a result needs the luma and divide steps, never appearing in the cycle after acceptance
  `ASSERT_NEXT(a_no_fast_result, clk_i, rst_ni, in_valid_i && in_ready_o, !$rose(out_valid_o))

endmodule

bind grayscale_block_downsample gbd_checker u_gbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .gray_average_o(gray_average_o),
  .bin_column_o  (bin_column_o)
);
